### rtl/rvsi_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the rate vector sector indicator.
`timescale 1ns / 1ps
package rvsi_pkg;

	// Field and register widths
	localparam int RATE_W      = 23;
	localparam int THR_W       = 22;
	localparam int OFF_W       = 16;
	localparam int IDX_W       = 3;
	localparam int CFG_DATA_W  = 22;
	localparam int CFG_INDEX_W = 1;

	// CORDIC sizing: 26 bits hold the negated input times the gain with margin
	localparam int CORDIC_W     = 26;
	localparam int PHASE_W      = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W       = 5;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET    = 1'd1;

	// Reset values of the registers
	localparam logic [THR_W-1:0] THR_RESET = 22'd50000;
	localparam logic [OFF_W-1:0] OFF_RESET = 16'd16384;

	// Operand select of the shared squaring multiplier
	typedef enum logic [1:0] {
		SQ_X = 2'd0,
		SQ_Y = 2'd1,
		SQ_T = 2'd2
	} sq_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load;
		sq_sel_t sq_sel;
		logic    prod_en;
		logic    acc_load;
		logic    acc_add;
		logic    cmp;
		logic    cordic_init;
		logic    cordic_step;
		logic    fin1;
		logic    fin2;
		logic    res_write;
	} rvsi_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic below;
		logic last;
	} rvsi_sts_t;

	// atan(2^-i) as a fraction of a turn, 2^-32 turn units
	function automatic logic [PHASE_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [PHASE_W-1:0] t;
		case (i)
			5'd0:    t = 32'd536870912;
			5'd1:    t = 32'd316933406;
			5'd2:    t = 32'd167458907;
			5'd3:    t = 32'd85004756;
			5'd4:    t = 32'd42667331;
			5'd5:    t = 32'd21354465;
			5'd6:    t = 32'd10679838;
			5'd7:    t = 32'd5340245;
			5'd8:    t = 32'd2670163;
			5'd9:    t = 32'd1335087;
			5'd10:   t = 32'd667544;
			5'd11:   t = 32'd333772;
			5'd12:   t = 32'd166886;
			5'd13:   t = 32'd83443;
			5'd14:   t = 32'd41722;
			5'd15:   t = 32'd20861;
			5'd16:   t = 32'd10430;
			5'd17:   t = 32'd5215;
			5'd18:   t = 32'd2608;
			5'd19:   t = 32'd1304;
			5'd20:   t = 32'd652;
			5'd21:   t = 32'd326;
			5'd22:   t = 32'd163;
			5'd23:   t = 32'd81;
			5'd24:   t = 32'd41;
			5'd25:   t = 32'd20;
			5'd26:   t = 32'd10;
			5'd27:   t = 32'd5;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

### rtl/rvsi_if.sv
// Valid/ready channel interfaces for rate samples and sector results.
`timescale 1ns / 1ps
interface rvsi_in_if import rvsi_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] x_rate;
	logic signed [RATE_W-1:0] y_rate;

	modport source (output valid, output x_rate, output y_rate, input ready);
	modport sink (input valid, input x_rate, input y_rate, output ready);
endinterface

interface rvsi_out_if import rvsi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             below_threshold;
	logic             changed;
	logic [IDX_W-1:0] old_index;
	logic [IDX_W-1:0] new_index;

	modport source (output valid, output below_threshold, output changed,
		output old_index, output new_index, input ready);
	modport sink (input valid, input below_threshold, input changed,
		input old_index, input new_index, output ready);
endinterface

### rtl/rate_vector_sector_indicator_core.sv
// Top level: XY rate vector to nearest LED sector, with threshold gating.
// Order: accept, squarings, threshold compare, CORDIC, rounding, sector, result.
// Below threshold, CORDIC and sector steps are skipped. No sample is taken until the three
// squarings through one shared multiplier and the 28 CORDIC iterations are done.
// The result register lets the next sample be taken while a result waits.
// Reset: arst_n clears control, the sector (to 0) and the registers to their defaults.
`timescale 1ns / 1ps
module rate_vector_sector_indicator_core import rvsi_pkg::*; #(
	parameter int LED_COUNT  = 8,
	parameter int ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rvsi_in_if.sink                sample,
	rvsi_out_if.source             result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	rvsi_cmd_t cmd;
	rvsi_sts_t sts;

	rvsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvsi_dp #(
		.LED_COUNT  (LED_COUNT),
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.x_rate          (sample.x_rate),
		.y_rate          (sample.y_rate),
		.cmd             (cmd),
		.sts             (sts),
		.below_threshold (result.below_threshold),
		.changed         (result.changed),
		.old_index       (result.old_index),
		.new_index       (result.new_index)
	);

	// A below-threshold word never moves the sector
	a_below_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.below_threshold) |->
		(!result.changed && (result.old_index == result.new_index)))
		else $error("below-threshold word reports a sector move");

	// The result register is only loaded when free
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_write |-> (!result.valid || result.ready))
		else $error("result word overwritten before it was taken");

	// No sample is taken while the CORDIC is iterating
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cordic_step |-> !sample.ready)
		else $error("sample accepted during CORDIC iterations");

	// A result is written only after a sample went through the compare
	a_write_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !cmd.res_write)
		else $error("result written straight after accept");

endmodule

### rtl/rvsi_ctrl.sv
// Sequencing state machine: squaring, threshold compare, CORDIC iterations, result hand-off.
`timescale 1ns / 1ps
module rvsi_ctrl import rvsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rvsi_sts_t sts,
	output rvsi_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQX  = 9'b000000010,
		S_SQY  = 9'b000000100,
		S_SQT  = 9'b000001000,
		S_CMP  = 9'b000010000,
		S_CRD  = 9'b000100000,
		S_FIN1 = 9'b001000000,
		S_FIN2 = 9'b010000000,
		S_RES  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   res_free;

	// Output register may be refilled when empty or being drained this cycle
	assign res_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sq_sel = SQ_X;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SQX;
				end
			end
			S_SQX: begin
				cmd.sq_sel  = SQ_X;
				cmd.prod_en = 1'b1;
				state_d     = S_SQY;
			end
			S_SQY: begin
				cmd.sq_sel   = SQ_Y;
				cmd.prod_en  = 1'b1;
				cmd.acc_load = 1'b1;
				state_d      = S_SQT;
			end
			S_SQT: begin
				cmd.sq_sel  = SQ_T;
				cmd.prod_en = 1'b1;
				cmd.acc_add = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				cmd.cmp         = 1'b1;
				cmd.cordic_init = 1'b1;
				state_d         = sts.below ? S_RES : S_CRD;
			end
			S_CRD: begin
				cmd.cordic_step = 1'b1;
				if (sts.last) begin
					state_d = S_FIN1;
				end
			end
			S_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d  = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d  = S_RES;
			end
			S_RES: begin
				if (res_free) begin
					cmd.res_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/rvsi_dp.sv
// Datapath: registers, shared squarer, threshold compare, CORDIC vectoring unit, sector quantiser.
`timescale 1ns / 1ps
module rvsi_dp import rvsi_pkg::*; #(
	parameter int LED_COUNT  = 8,
	parameter int ANGLE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic signed [RATE_W-1:0] x_rate,
	input  logic signed [RATE_W-1:0] y_rate,
	input  rvsi_cmd_t                cmd,
	output rvsi_sts_t                sts,
	output logic                     below_threshold,
	output logic                     changed,
	output logic [IDX_W-1:0]         old_index,
	output logic [IDX_W-1:0]         new_index
);

	localparam int SW     = $clog2(LED_COUNT);
	localparam int MW     = ANGLE_BITS + SW + 1;
	localparam int SQ_W   = 2 * RATE_W;
	localparam logic [PHASE_W-1:0] ROUND_ADD = PHASE_W'(1) << (PHASE_W - 1 - ANGLE_BITS);

	// Configuration and sector state
	logic [THR_W-1:0] thr_q;
	logic [OFF_W-1:0] off_q;
	logic [SW-1:0]    cur_q;

	// Captured sample and magnitude terms
	logic signed [RATE_W-1:0] x_q, y_q;
	logic [RATE_W-1:0]        ax, ay, mul_a;
	logic [SQ_W-1:0]          prod, prod_q, acc_q;
	logic                     below_q;

	// CORDIC registers
	logic signed [CORDIC_W-1:0] cx_q, cy_q, cx_init, cy_init, dx, dy;
	logic [PHASE_W-1:0]         z_q, z_round;
	logic [STEP_W-1:0]          step_q;
	logic                       y_pos;

	// Quantiser
	logic [ANGLE_BITS-1:0] ang, off_s, ang_q;
	logic [MW-1:0]         scaled;
	logic [SW+1:0]         q_inc;
	logic [SW:0]           sect_r;
	logic [SW-1:0]         sect, sect_q;
	logic [SW+2:0]         cur_ext, sect_ext;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			off_q <= OFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				REG_OFFSET:    off_q <= cfg_wdata[OFF_W-1:0];
				default:       ;
			endcase
		end
	end

	// Shared squarer: |x|, |y| and threshold in turn
	assign ax = x_q[RATE_W-1] ? RATE_W'(-x_q) : RATE_W'(x_q);
	assign ay = y_q[RATE_W-1] ? RATE_W'(-y_q) : RATE_W'(y_q);

	always_comb begin
		case (cmd.sq_sel)
			SQ_X:    mul_a = ax;
			SQ_Y:    mul_a = ay;
			SQ_T:    mul_a = {1'b0, thr_q};
			default: mul_a = '0;
		endcase
	end

	assign prod      = SQ_W'(mul_a) * SQ_W'(mul_a);
	assign sts.below = acc_q < prod_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_rate;
			y_q <= y_rate;
		end
		if (cmd.prod_en) begin
			prod_q <= prod;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.cmp) begin
			below_q <= sts.below;
		end
	end

	// CORDIC start: fold the left half-plane onto the right
	always_comb begin
		cx_init = {{(CORDIC_W-RATE_W){x_q[RATE_W-1]}}, x_q};
		cy_init = {{(CORDIC_W-RATE_W){y_q[RATE_W-1]}}, y_q};
		if (x_q[RATE_W-1]) begin
			cx_init = -cx_init;
			cy_init = -cy_init;
		end
	end

	// One vectoring micro-rotation per cycle
	assign dx       = cy_q >>> step_q;
	assign dy       = cx_q >>> step_q;
	assign y_pos    = !cy_q[CORDIC_W-1] && (cy_q != '0);
	assign sts.last = (step_q == STEP_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			cx_q   <= cx_init;
			cy_q   <= cy_init;
			z_q    <= x_q[RATE_W-1] ? {1'b1, {(PHASE_W-1){1'b0}}} : '0;
			step_q <= '0;
		end else if (cmd.cordic_step) begin
			if (y_pos) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + atan_turn(step_q);
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - atan_turn(step_q);
			end
			step_q <= step_q + 1'b1;
		end
	end

	// Round the phase to the angle width and add the scaled offset
	assign z_round = z_q + ROUND_ADD;
	assign ang     = z_round[PHASE_W-1 -: ANGLE_BITS];

	generate
		if (ANGLE_BITS >= OFF_W) begin : g_off_up
			assign off_s = ANGLE_BITS'({off_q, {(ANGLE_BITS-OFF_W+1){1'b0}}} >> 1);
		end else begin : g_off_down
			assign off_s = off_q[OFF_W-1 -: ANGLE_BITS];
		end
	endgenerate

	// Nearest sector, wrapping the top half-sector back to zero
	assign scaled = MW'(ang_q) * MW'(2 * LED_COUNT);
	assign q_inc  = (SW+2)'(scaled[MW-1:ANGLE_BITS]) + (SW+2)'(1);
	assign sect_r = q_inc[SW+1:1];
	assign sect   = (sect_r == (SW+1)'(LED_COUNT)) ? '0 : sect_r[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.fin1) begin
			ang_q <= ang + off_s;
		end
		if (cmd.fin2) begin
			sect_q <= sect;
		end
	end

	// Result word and sector state
	assign cur_ext  = {3'b000, cur_q};
	assign sect_ext = {3'b000, sect_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cmd.res_write && !below_q) begin
			cur_q <= sect_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			below_threshold <= below_q;
			old_index       <= cur_ext[IDX_W-1:0];
			if (below_q) begin
				changed   <= 1'b0;
				new_index <= cur_ext[IDX_W-1:0];
			end else begin
				changed   <= (cur_q != sect_q);
				new_index <= sect_ext[IDX_W-1:0];
			end
		end
	end

endmodule
